// ===== design/des_rkg_pkg.sv =====
`default_nettype none

package des_rkg_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned CdW     = 56;
  localparam int unsigned HalfW   = 28;
  localparam int unsigned SubkeyW = 48;
  localparam int unsigned RoundW  = 4;
  localparam int unsigned Rounds  = 16;

  localparam logic [RoundW-1:0] LastRound = RoundW'(Rounds - 1);

  typedef logic [HalfW-1:0]   half_t;
  typedef logic [CdW-1:0]     cd_t;
  typedef logic [SubkeyW-1:0] subkey_t;
  typedef logic [RoundW-1:0]  round_t;

  // Standard tables, 1-based positions with bit 1 the MSB
  localparam logic [6:0] PC1_TAB [CdW] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [SubkeyW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Bit r set: round r rotates by two, else by one
  localparam logic [Rounds-1:0] SHIFT_TWO = 16'b0111_1110_1111_1100;

  function automatic cd_t pc1(input logic [KeyW-1:0] key);
    cd_t res;
    res = '0;
    for (int i = 0; i < CdW; i++) begin
      res[CdW-1-i] = key[KeyW-int'(PC1_TAB[i])];
    end
    return res;
  endfunction

  function automatic subkey_t pc2(input cd_t cd);
    subkey_t res;
    res = '0;
    for (int i = 0; i < SubkeyW; i++) begin
      res[SubkeyW-1-i] = cd[CdW-int'(PC2_TAB[i])];
    end
    return res;
  endfunction

  function automatic half_t rot_half(input half_t v, input logic two);
    return two ? {v[HalfW-3:0], v[HalfW-1:HalfW-2]} : {v[HalfW-2:0], v[HalfW-1]};
  endfunction

endpackage

`default_nettype wire

// ===== design/des_round_key_generator.sv =====
`default_nettype none

// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  in_cipher_key[63:0]
// out_     out  out_valid/out_stall out_subkey[47:0], out_round_index[3:0], out_last_round
//
// One key yields sixteen subkeys, one a cycle while out_stall is low, through the single
// rotate/PC-2 path between the half registers and the output register. The next key is
// taken on the cycle the sixteenth subkey is loaded.
// The first subkey goes from the loaded half registers to the output register. Synchronous
// active-low reset empties the block; out_stall freezes rounds while out_valid is high.

module des_round_key_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_cipher_key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_subkey,
  output logic [3:0]       out_round_index,
  output logic             out_last_round
);

  logic                    busy_r, busy_nxt;
  des_rkg_pkg::half_t      c_r, c_nxt;
  des_rkg_pkg::half_t      d_r, d_nxt;
  des_rkg_pkg::round_t     round_r, round_nxt;
  logic                    out_valid_r, out_valid_nxt;
  des_rkg_pkg::subkey_t    subkey_r, subkey_nxt;
  des_rkg_pkg::round_t     index_r, index_nxt;
  logic                    last_r, last_nxt;

  logic                    advance;
  logic                    finishing;
  logic                    in_take;
  logic                    two;
  des_rkg_pkg::half_t      c_rot, d_rot;
  des_rkg_pkg::cd_t        key_cd;

  assign advance   = busy_r && (!out_valid_r || !out_stall);
  assign finishing = advance && (round_r == des_rkg_pkg::LastRound);
  assign in_stall  = busy_r && !finishing;
  assign in_take   = in_valid && !in_stall;

  assign two    = des_rkg_pkg::SHIFT_TWO[round_r];
  assign c_rot  = des_rkg_pkg::rot_half(c_r, two);
  assign d_rot  = des_rkg_pkg::rot_half(d_r, two);
  assign key_cd = des_rkg_pkg::pc1(in_cipher_key);

  always_comb begin
    busy_nxt      = busy_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r && out_stall;
    subkey_nxt    = subkey_r;
    index_nxt     = index_r;
    last_nxt      = last_r;

    if (advance) begin
      // emit this round's word and keep the rotated halves
      c_nxt         = c_rot;
      d_nxt         = d_rot;
      round_nxt     = round_r + des_rkg_pkg::round_t'(1);
      out_valid_nxt = 1'b1;
      subkey_nxt    = des_rkg_pkg::pc2({c_rot, d_rot});
      index_nxt     = round_r;
      last_nxt      = (round_r == des_rkg_pkg::LastRound);
      if (finishing) begin
        busy_nxt = 1'b0;
      end
    end

    if (in_take) begin
      busy_nxt  = 1'b1;
      c_nxt     = key_cd[des_rkg_pkg::CdW-1:des_rkg_pkg::HalfW];
      d_nxt     = key_cd[des_rkg_pkg::HalfW-1:0];
      round_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      c_r         <= '0;
      d_r         <= '0;
    end else begin
      busy_r      <= busy_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      c_r         <= c_nxt;
      d_r         <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    subkey_r <= subkey_nxt;
    index_r  <= index_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_subkey      = subkey_r;
  assign out_round_index = index_r;
  assign out_last_round  = last_r;

`ifndef SYNTH
  a_last_is_round15: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (index_r == des_rkg_pkg::LastRound)))
    else $error("last flag disagrees with round index");

  a_take_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && busy_r) |-> (round_r == des_rkg_pkg::LastRound))
    else $error("key taken before sixteenth round");

  a_rounds_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (round_r != des_rkg_pkg::LastRound)) |=> busy_r)
    else $error("rounds dropped before sixteenth");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && (index_r != des_rkg_pkg::LastRound))
      |=> (out_valid_r && (index_r == des_rkg_pkg::round_t'($past(index_r) + 1'b1))))
    else $error("round index did not advance by one");
`endif

endmodule

`default_nettype wire
